// ===== rtl/tlc_pkg.sv =====
`timescale 1ns / 1ps
package tlc_pkg;
    localparam int L1_LINES   = 8;
    localparam int L2_LINES   = 16;
    localparam int L3_LINES   = 32;
    localparam int ADDR_W     = 16;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = $clog2(L3_LINES);
    localparam int COST_W     = 18;
    localparam int SUM_W      = 48;
    localparam int REG_W      = 16;

    localparam logic [1:0] POL_LRU     = 2'd0;
    localparam logic [1:0] POL_LFU     = 2'd1;
    localparam logic [1:0] POL_FIFO    = 2'd2;
    localparam logic [1:0] POL_LRU_ALT = 2'd3;

    localparam logic [2:0] REG_POLICY = 3'd0;
    localparam logic [2:0] REG_COST1  = 3'd1;
    localparam logic [2:0] REG_COST2  = 3'd2;
    localparam logic [2:0] REG_COST3  = 3'd3;
    localparam logic [2:0] REG_COSTM  = 3'd4;

    localparam logic [1:0] LVL_L1  = 2'd0;
    localparam logic [1:0] LVL_L2  = 2'd1;
    localparam logic [1:0] LVL_L3  = 2'd2;
    localparam logic [1:0] LVL_MEM = 2'd3;

    typedef logic [IDX_W-1:0] t_idx;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              hit;
        t_idx              hit_idx;
        logic              inv;
        t_idx              inv_idx;
        logic [CNT_W-1:0]  best_cnt;
        t_idx              best_idx;
        logic [ADDR_W-1:0] best_tag;
        logic              best_dirty;
    } t_tok;

    // update broadcast to every cell of one level
    typedef struct packed {
        logic              age;
        logic              hit_en;
        t_idx              hit_idx;
        logic              hit_lfu;
        logic              hit_zero;
        logic              hit_dirty;
        logic              fill_en;
        t_idx              fill_idx;
        logic [ADDR_W-1:0] fill_tag;
        logic              fill_dirty;
    } t_cmd;
endpackage

// ===== rtl/tlc_cell.sv =====
`timescale 1ns / 1ps
module tlc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tlc_pkg::t_idx              i_idx,
    input  logic [tlc_pkg::ADDR_W-1:0] i_addr,
    input  logic                       i_lfu,
    input  tlc_pkg::t_cmd              i_cmd,
    input  tlc_pkg::t_tok              i_tok,
    input  logic                       i_tok_vld,
    output tlc_pkg::t_tok              o_tok,
    output logic                       o_tok_vld
);
    logic [tlc_pkg::ADDR_W-1:0] r_tag, n_tag;
    logic                       r_valid, n_valid;
    logic                       r_dirty, n_dirty;
    logic [tlc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [tlc_pkg::CNT_W-1:0]  cnt_inc;
    tlc_pkg::t_tok              r_tok, n_tok;
    logic                       r_tok_vld;
    logic                       better;

    assign cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_tag   = r_tag;
        n_valid = r_valid;
        n_dirty = r_dirty;
        n_cnt   = r_cnt;
        if (i_cmd.age && r_valid) begin
            n_cnt = cnt_inc;
        end
        if (i_cmd.hit_en && i_cmd.hit_idx == i_idx) begin
            if (i_cmd.hit_lfu) begin
                n_cnt = cnt_inc;
            end
            if (i_cmd.hit_zero) begin
                n_cnt = '0;
            end
            if (i_cmd.hit_dirty) begin
                n_dirty = 1'b1;
            end
        end
        if (i_cmd.fill_en && i_cmd.fill_idx == i_idx) begin
            n_tag   = i_cmd.fill_tag;
            n_valid = 1'b1;
            n_dirty = i_cmd.fill_dirty;
            n_cnt   = '0;
        end
    end

    assign better = i_lfu ? (r_cnt < i_tok.best_cnt) : (r_cnt > i_tok.best_cnt);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit && r_valid && r_tag == i_addr) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = i_idx;
        end
        if (!i_tok.inv && !r_valid) begin
            n_tok.inv     = 1'b1;
            n_tok.inv_idx = i_idx;
        end
        // first cell seeds the running best, later cells replace only on strict win
        if (i_idx == '0 || better) begin
            n_tok.best_cnt   = r_cnt;
            n_tok.best_idx   = i_idx;
            n_tok.best_tag   = r_tag;
            n_tok.best_dirty = r_dirty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_dirty   <= 1'b0;
            r_cnt     <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_dirty   <= n_dirty;
            r_cnt     <= n_cnt;
            r_tok_vld <= i_tok_vld;
        end
    end

    assign o_tok     = r_tok;
    assign o_tok_vld = r_tok_vld;
endmodule

// ===== rtl/three_level_cache_tag_hierarchy.sv =====
`timescale 1ns / 1ps
// an accepted start passes through an aging state, then the scan token is launched and
// walks the 32-cell L3 row, the row results are collected, and an update state registers
// the outputs ahead of the o_done strobe
// a new start is taken only once the block is back in the idle state, after the last
// transaction is through; results are shown for one cycle under o_done, the receiver cannot stall
// synchronous active-low reset clears all valid, dirty and counter state and the total
module three_level_cache_tag_hierarchy (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tlc_pkg::ADDR_W-1:0]  i_block_address,
    input  logic                        i_is_write,
    output logic                        o_done,
    output logic [1:0]                  o_hit_level,
    output logic [tlc_pkg::COST_W-1:0]  o_access_cost,
    output logic [tlc_pkg::SUM_W-1:0]   o_total_cost,
    output logic                        o_writeback_valid,
    output logic [tlc_pkg::ADDR_W-1:0]  o_writeback_block,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [4:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_AGE   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                 r_policy;
    logic [tlc_pkg::REG_W-1:0]  r_cost1, r_cost2, r_cost3, r_costm;
    logic [tlc_pkg::ADDR_W-1:0] r_addr;
    logic                       r_wr;
    logic                       r_go;
    logic [2:0]                 r_got;
    tlc_pkg::t_tok              r_res1, r_res2, r_res3;
    logic [tlc_pkg::SUM_W-1:0]  r_sum;

    tlc_pkg::t_cmd cmd1, cmd2, cmd3;
    logic          lfu;
    logic          lru;

    tlc_pkg::t_tok tok1 [tlc_pkg::L1_LINES+1];
    tlc_pkg::t_tok tok2 [tlc_pkg::L2_LINES+1];
    tlc_pkg::t_tok tok3 [tlc_pkg::L3_LINES+1];
    logic [tlc_pkg::L1_LINES:0] vld1;
    logic [tlc_pkg::L2_LINES:0] vld2;
    logic [tlc_pkg::L3_LINES:0] vld3;

    assign lfu = (r_policy == tlc_pkg::POL_LFU);
    assign lru = (r_policy != tlc_pkg::POL_LFU) && (r_policy != tlc_pkg::POL_FIFO);

    assign tok1[0] = '0;
    assign tok2[0] = '0;
    assign tok3[0] = '0;
    assign vld1[0] = r_go;
    assign vld2[0] = r_go;
    assign vld3[0] = r_go;

    for (genvar i = 0; i < tlc_pkg::L1_LINES; i++) begin : g_l1
        tlc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(tlc_pkg::IDX_W'(i)),
            .i_addr(r_addr), .i_lfu(lfu), .i_cmd(cmd1),
            .i_tok(tok1[i]), .i_tok_vld(vld1[i]),
            .o_tok(tok1[i+1]), .o_tok_vld(vld1[i+1])
        );
    end
    for (genvar i = 0; i < tlc_pkg::L2_LINES; i++) begin : g_l2
        tlc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(tlc_pkg::IDX_W'(i)),
            .i_addr(r_addr), .i_lfu(lfu), .i_cmd(cmd2),
            .i_tok(tok2[i]), .i_tok_vld(vld2[i]),
            .o_tok(tok2[i+1]), .o_tok_vld(vld2[i+1])
        );
    end
    for (genvar i = 0; i < tlc_pkg::L3_LINES; i++) begin : g_l3
        tlc_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_idx(tlc_pkg::IDX_W'(i)),
            .i_addr(r_addr), .i_lfu(lfu), .i_cmd(cmd3),
            .i_tok(tok3[i]), .i_tok_vld(vld3[i]),
            .o_tok(tok3[i+1]), .o_tok_vld(vld3[i+1])
        );
    end

    // victim of each level: first invalid line, else the policy's best line
    tlc_pkg::t_idx v1, v2, v3;
    logic          v1d, v2d, v3d;
    logic [1:0]    level;

    assign v1  = r_res1.inv ? r_res1.inv_idx : r_res1.best_idx;
    assign v2  = r_res2.inv ? r_res2.inv_idx : r_res2.best_idx;
    assign v3  = r_res3.inv ? r_res3.inv_idx : r_res3.best_idx;
    assign v1d = !r_res1.inv && r_res1.best_dirty;
    assign v2d = !r_res2.inv && r_res2.best_dirty;
    assign v3d = !r_res3.inv && r_res3.best_dirty;

    always_comb begin
        if (r_res1.hit) begin
            level = tlc_pkg::LVL_L1;
        end else if (r_res2.hit) begin
            level = tlc_pkg::LVL_L2;
        end else if (r_res3.hit) begin
            level = tlc_pkg::LVL_L3;
        end else begin
            level = tlc_pkg::LVL_MEM;
        end
    end

    always_comb begin
        cmd1 = '0;
        cmd2 = '0;
        cmd3 = '0;
        if (r_state == S_AGE && r_policy == tlc_pkg::POL_FIFO) begin
            cmd1.age = 1'b1;
            cmd2.age = 1'b1;
            cmd3.age = 1'b1;
        end
        if (r_state == S_APPLY) begin
            case (level)
                tlc_pkg::LVL_L1: begin
                    cmd1.age       = lru;
                    cmd1.hit_en    = 1'b1;
                    cmd1.hit_idx   = r_res1.hit_idx;
                    cmd1.hit_lfu   = lfu;
                    cmd1.hit_zero  = lru;
                    cmd1.hit_dirty = r_wr;
                end
                tlc_pkg::LVL_L2: begin
                    cmd2.age       = lru;
                    cmd2.hit_en    = 1'b1;
                    cmd2.hit_idx   = r_res2.hit_idx;
                    cmd2.hit_lfu   = lfu;
                    cmd2.hit_zero  = lru;
                    cmd2.hit_dirty = r_wr;
                end
                tlc_pkg::LVL_L3: begin
                    cmd3.age       = lru;
                    cmd3.hit_en    = 1'b1;
                    cmd3.hit_idx   = r_res3.hit_idx;
                    cmd3.hit_lfu   = lfu;
                    cmd3.hit_zero  = lru;
                    cmd3.hit_dirty = r_wr;
                end
                default: begin
                    cmd1.fill_en    = 1'b1;
                    cmd1.fill_idx   = v1;
                    cmd1.fill_tag   = r_addr;
                    cmd1.fill_dirty = r_wr;
                    cmd2.fill_en    = v1d;
                    cmd2.fill_idx   = v2;
                    cmd2.fill_tag   = r_res1.best_tag;
                    cmd2.fill_dirty = 1'b1;
                    cmd3.fill_en    = v1d && v2d;
                    cmd3.fill_idx   = v3;
                    cmd3.fill_tag   = r_res2.best_tag;
                    cmd3.fill_dirty = 1'b1;
                end
            endcase
        end
    end

    logic [tlc_pkg::COST_W-1:0] cost;
    logic [tlc_pkg::SUM_W:0]    sum_ext;

    always_comb begin
        cost = tlc_pkg::COST_W'(r_cost1);
        if (level != tlc_pkg::LVL_L1) begin
            cost = cost + tlc_pkg::COST_W'(r_cost2);
        end
        if (level == tlc_pkg::LVL_L3 || level == tlc_pkg::LVL_MEM) begin
            cost = cost + tlc_pkg::COST_W'(r_cost3);
        end
        if (level == tlc_pkg::LVL_MEM) begin
            cost = cost + tlc_pkg::COST_W'(r_costm);
        end
    end

    assign sum_ext = {1'b0, r_sum} + (tlc_pkg::SUM_W + 1)'(cost);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_AGE;
            S_AGE:   n_state = S_SCAN;
            S_SCAN:  if (r_got == 3'b111) n_state = S_APPLY;
            S_APPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:2])
            tlc_pkg::REG_POLICY: prdata = {30'd0, r_policy};
            tlc_pkg::REG_COST1:  prdata = {16'd0, r_cost1};
            tlc_pkg::REG_COST2:  prdata = {16'd0, r_cost2};
            tlc_pkg::REG_COST3:  prdata = {16'd0, r_cost3};
            tlc_pkg::REG_COSTM:  prdata = {16'd0, r_costm};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_addr <= i_block_address;
            r_wr   <= i_is_write;
        end
        if (vld1[tlc_pkg::L1_LINES]) r_res1 <= tok1[tlc_pkg::L1_LINES];
        if (vld2[tlc_pkg::L2_LINES]) r_res2 <= tok2[tlc_pkg::L2_LINES];
        if (vld3[tlc_pkg::L3_LINES]) r_res3 <= tok3[tlc_pkg::L3_LINES];
        if (r_state == S_APPLY) begin
            o_hit_level       <= level;
            o_access_cost     <= cost;
            o_total_cost      <= sum_ext[tlc_pkg::SUM_W] ? '1 : sum_ext[tlc_pkg::SUM_W-1:0];
            o_writeback_valid <= (level == tlc_pkg::LVL_MEM) && v1d && v2d && v3d;
            o_writeback_block <= ((level == tlc_pkg::LVL_MEM) && v1d && v2d && v3d)
                                 ? r_res3.best_tag : '0;
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
            r_got    <= 3'b000;
            r_sum    <= '0;
            o_done   <= 1'b0;
            r_policy <= tlc_pkg::POL_LRU;
            r_cost1  <= 16'd1;
            r_cost2  <= 16'd10;
            r_cost3  <= 16'd100;
            r_costm  <= 16'd1000;
        end else begin
            r_state <= n_state;
            r_go    <= (r_state == S_AGE);
            o_done  <= (r_state == S_APPLY);
            if (r_state == S_AGE) begin
                r_got <= 3'b000;
            end else begin
                r_got <= r_got | {vld3[tlc_pkg::L3_LINES], vld2[tlc_pkg::L2_LINES],
                                  vld1[tlc_pkg::L1_LINES]};
            end
            if (r_state == S_APPLY) begin
                r_sum <= sum_ext[tlc_pkg::SUM_W] ? '1 : sum_ext[tlc_pkg::SUM_W-1:0];
            end
            if (cfg_wr) begin
                case (paddr[4:2])
                    tlc_pkg::REG_POLICY: r_policy <= pwdata[1:0];
                    tlc_pkg::REG_COST1:  r_cost1  <= pwdata[15:0];
                    tlc_pkg::REG_COST2:  r_cost2  <= pwdata[15:0];
                    tlc_pkg::REG_COST3:  r_cost3  <= pwdata[15:0];
                    tlc_pkg::REG_COSTM:  r_costm  <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== rtl/tlc_checker.sv =====
`timescale 1ns / 1ps
module tlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_hit_level,
    input logic        o_writeback_valid
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("two results back to back");

    a_wb_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_writeback_valid |-> o_hit_level == tlc_pkg::LVL_MEM)
        else $error("write-back reported without a full miss");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_done) else $error("reset did not clear control");
endmodule

bind three_level_cache_tag_hierarchy tlc_checker u_tlc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_hit_level(o_hit_level), .o_writeback_valid(o_writeback_valid)
);
